// ===== src/lzss_pkg.sv =====
// Shared constants and controller/datapath interface types for the LZSS decompressor.
package lzss_pkg;

  localparam int WIN_DEPTH      = 4096;
  localparam int WIN_AW         = 12;
  localparam int BYTE_W         = 8;
  localparam int LEN_W          = 24;
  localparam int FLAG_CNT_W     = 4;
  localparam int BREAK_EVEN_DEF = 1;

  typedef struct packed {
    logic lit_put;      // commit the input byte as a literal
    logic empty_put;    // post a data-less truncation word
    logic tok_hi_load;  // capture first token byte
    logic copy_start;   // load copy run from second token byte
    logic copy_step;    // advance the copy run
  } cmd_t;

  typedef struct packed {
    logic adv;          // output register can take a word this cycle
    logic len_reached;  // produced count at or past output length
    logic copy_last;    // last byte of the copy run commits this cycle
    logic done_now;     // final expected byte commits this cycle
  } sts_t;

endpackage

// ===== src/lzss_ctrl.sv =====
// Parse controller: flag byte tracking and item sequencing for the LZSS decompressor.
module lzss_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lzss_pkg::BYTE_W-1:0]  in_comp_byte,
  input  logic                         in_end_of_input,
  input  lzss_pkg::sts_t               sts,
  output lzss_pkg::cmd_t               cmd
);

  typedef enum logic [1:0] {
    ST_FLAG,
    ST_ITEM,
    ST_LOW,
    ST_COPY
  } state_t;

  state_t                            state_r, state_nxt;
  logic [lzss_pkg::BYTE_W-1:0]       flag_bits_r, flag_bits_nxt;
  logic [lzss_pkg::FLAG_CNT_W-1:0]   flag_left_r, flag_left_nxt;
  logic                              finished_r, finished_nxt;
  logic                              acc;
  logic                              work;

  assign in_ready = sts.adv && (state_r != ST_COPY);
  assign acc      = in_valid && in_ready;
  // drop bytes once the stream is complete or truncated
  assign work     = acc && !finished_r && !sts.len_reached;

  always_comb begin
    state_nxt     = state_r;
    flag_bits_nxt = flag_bits_r;
    flag_left_nxt = flag_left_r;
    cmd           = '0;
    unique case (state_r)
      ST_FLAG: begin
        if (work) begin
          flag_bits_nxt = in_comp_byte;
          flag_left_nxt = lzss_pkg::FLAG_CNT_W'(lzss_pkg::BYTE_W);
          state_nxt     = ST_ITEM;
          cmd.empty_put = in_end_of_input;
        end
      end
      ST_ITEM: begin
        if (work) begin
          flag_bits_nxt = flag_bits_r >> 1;
          flag_left_nxt = flag_left_r - lzss_pkg::FLAG_CNT_W'(1);
          if (flag_bits_r[0]) begin
            cmd.lit_put = 1'b1;
            state_nxt   = (flag_left_nxt != '0) ? ST_ITEM : ST_FLAG;
          end else begin
            cmd.tok_hi_load = 1'b1;
            cmd.empty_put   = in_end_of_input;
            state_nxt       = ST_LOW;
          end
        end
      end
      ST_LOW: begin
        if (work) begin
          cmd.copy_start = 1'b1;
          state_nxt      = ST_COPY;
        end
      end
      ST_COPY: begin
        cmd.copy_step = 1'b1;
        if (sts.copy_last) begin
          state_nxt = (flag_left_r != '0) ? ST_ITEM : ST_FLAG;
        end
      end
      default: state_nxt = ST_FLAG;
    endcase
  end

  assign finished_nxt = finished_r || (work && in_end_of_input) || sts.done_now;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FLAG;
      flag_bits_r <= '0;
      flag_left_r <= '0;
      finished_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      flag_bits_r <= flag_bits_nxt;
      flag_left_r <= flag_left_nxt;
      finished_r  <= finished_nxt;
    end
  end

  a_copy_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COPY) |-> !in_ready)
    else $error("input taken during copy run");

  a_start_enters_copy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.copy_start |=> (state_r == ST_COPY))
    else $error("copy start did not enter copy state");

  a_finished_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |=> finished_r)
    else $error("finished flag cleared without reset");

endmodule

// ===== src/lzss_dpath.sv =====
// Datapath: history window, copy sequencing, counters and output register.
module lzss_dpath #(
  parameter int BREAK_EVEN = lzss_pkg::BREAK_EVEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lzss_pkg::cmd_t               cmd,
  output lzss_pkg::sts_t               sts,
  input  logic [lzss_pkg::BYTE_W-1:0]  in_comp_byte,
  input  logic                         in_end_of_input,
  input  logic                         cfg_valid,
  input  logic [lzss_pkg::LEN_W-1:0]   cfg_output_length,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lzss_pkg::BYTE_W-1:0]  out_plain_byte,
  output logic                         out_has_data,
  output logic                         out_run_last,
  output logic                         out_stream_done,
  output logic                         out_truncated
);

  localparam int AW    = lzss_pkg::WIN_AW;
  localparam int BW    = lzss_pkg::BYTE_W;
  localparam int LW    = lzss_pkg::LEN_W;
  localparam int CNT_W = $clog2(16 + BREAK_EVEN + 1);
  localparam logic [CNT_W-1:0] TOK_ADD  = CNT_W'(BREAK_EVEN + 1);
  localparam logic [AW:0]      FILL_MAX = (AW + 1)'(lzss_pkg::WIN_DEPTH);

  logic [BW-1:0]    mem [lzss_pkg::WIN_DEPTH];
  logic [BW-1:0]    mem_q_r;
  logic             hit_r, fwd_r;
  logic [BW-1:0]    fwd_data_r;
  logic [AW-1:0]    wp_r, cp_addr_r;
  logic [AW:0]      fill_r;
  logic [LW-1:0]    produced_r, out_len_r;
  logic [BW-1:0]    token_high_r;
  logic             p1_v_r;
  logic [CNT_W-1:0] rd_left_r;
  logic             cp_eoi_r;
  logic             out_valid_r, out_has_data_r, out_run_last_r;
  logic             out_stream_done_r, out_truncated_r;
  logic [BW-1:0]    out_plain_byte_r;

  logic             adv, commit_cp, put, done_now, last_cp, rd_en, hit_nxt, fwd_nxt;
  logic             run_last, trunc_src;
  logic [BW-1:0]    cp_byte, put_byte;
  logic [LW-1:0]    produced_inc, left;
  logic [AW-1:0]    start_addr, rd_addr;
  logic [CNT_W-1:0] tok_n, n_clamp;

  assign adv          = !out_valid_r || out_ready;
  assign commit_cp    = cmd.copy_step && adv && p1_v_r;
  assign cp_byte      = fwd_r ? fwd_data_r : (hit_r ? mem_q_r : '0);
  assign put          = cmd.lit_put || commit_cp;
  assign put_byte     = cmd.lit_put ? in_comp_byte : cp_byte;
  assign produced_inc = produced_r + LW'(1);
  assign done_now     = put && (produced_inc >= out_len_r);
  assign last_cp      = commit_cp && (rd_left_r == '0);
  assign run_last     = cmd.lit_put || last_cp;
  assign trunc_src    = cmd.lit_put ? in_end_of_input : cp_eoi_r;

  assign start_addr = {token_high_r[3:0], in_comp_byte};
  assign tok_n      = CNT_W'(token_high_r[7:4]) + TOK_ADD;
  assign left       = out_len_r - produced_r;
  assign n_clamp    = (left < LW'(tok_n)) ? left[CNT_W-1:0] : tok_n;

  assign rd_en   = cmd.copy_start || (commit_cp && (rd_left_r != '0));
  assign rd_addr = cmd.copy_start ? start_addr : cp_addr_r;
  // entries written so far form a run starting at position one
  assign hit_nxt = {1'b0, rd_addr - AW'(1)} < fill_r;
  // read-first memory: pass through a byte written in the same cycle
  assign fwd_nxt = put && (rd_addr == wp_r);

  assign sts.adv         = adv;
  assign sts.len_reached = produced_r >= out_len_r;
  assign sts.copy_last   = last_cp;
  assign sts.done_now    = done_now;

  always_ff @(posedge clk) begin
    if (put) begin
      mem[wp_r] <= put_byte;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      hit_r      <= hit_nxt;
      fwd_r      <= fwd_nxt;
      fwd_data_r <= put_byte;
    end
    if (cmd.tok_hi_load) begin
      token_high_r <= in_comp_byte;
    end
    if (cmd.copy_start) begin
      cp_addr_r <= start_addr + AW'(1);
      cp_eoi_r  <= in_end_of_input;
    end else if (commit_cp) begin
      cp_addr_r <= cp_addr_r + AW'(1);
    end
    if (put) begin
      out_plain_byte_r  <= put_byte;
      out_has_data_r    <= 1'b1;
      out_run_last_r    <= run_last;
      out_stream_done_r <= done_now;
      out_truncated_r   <= run_last && trunc_src && !done_now;
    end else if (cmd.empty_put) begin
      out_plain_byte_r  <= '0;
      out_has_data_r    <= 1'b0;
      out_run_last_r    <= 1'b1;
      out_stream_done_r <= 1'b0;
      out_truncated_r   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= AW'(1);
      fill_r      <= '0;
      produced_r  <= '0;
      out_len_r   <= '0;
      p1_v_r      <= 1'b0;
      rd_left_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        out_len_r <= cfg_output_length;
      end
      if (put) begin
        wp_r       <= wp_r + AW'(1);
        produced_r <= produced_inc;
        if (fill_r != FILL_MAX) begin
          fill_r <= fill_r + (AW + 1)'(1);
        end
      end
      if (cmd.copy_start) begin
        p1_v_r    <= 1'b1;
        rd_left_r <= n_clamp - CNT_W'(1);
      end else if (commit_cp) begin
        if (rd_left_r != '0) begin
          rd_left_r <= rd_left_r - CNT_W'(1);
        end else begin
          p1_v_r <= 1'b0;
        end
      end
      if (put || cmd.empty_put) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_plain_byte  = out_plain_byte_r;
  assign out_has_data    = out_has_data_r;
  assign out_run_last    = out_run_last_r;
  assign out_stream_done = out_stream_done_r;
  assign out_truncated   = out_truncated_r;

  a_fill_tracks_wp: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r < FILL_MAX) |-> (wp_r == AW'(fill_r + (AW + 1)'(1))))
    else $error("write pointer and fill count disagree");

  a_reads_need_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_left_r != '0) |-> p1_v_r)
    else $error("pending copy reads without a staged byte");

  a_stage_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(p1_v_r) |-> $past(cmd.copy_start))
    else $error("copy stage filled without a token");

  a_empty_is_trunc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_has_data_r) |-> (out_truncated_r && out_run_last_r))
    else $error("data-less word without truncation mark");

endmodule

// ===== src/lzss_stream_decompressor_core.sv =====
// Top level of the LZSS stream decompressor with a 4096-byte history window.
// Usage:
//   Input channel (in_valid/in_ready) carries one compressed byte per word, with
//   in_end_of_input marking the last byte of the stream. Output channel
//   (out_valid/out_ready) carries one decompressed byte per word plus status:
//   out_run_last closes the words caused by one input word, out_stream_done marks
//   the final expected byte, out_truncated flags an input that ended too early.
//   The config channel (cfg_valid/cfg_ready) writes the expected output length;
//   write it only while the block is idle. Zero length yields nothing.
// Timing:
//   Flag and first token bytes are accepted without dropping in_ready. A literal
//   lands in the output register in the cycle after acceptance. A match token of n
//   bytes (n up to 16 + BREAK_EVEN) drops in_ready until its copy run ends, so the
//   next word waits for the run: one window read is issued at acceptance, then
//   one byte is written back and emitted per cycle while the output advances, set
//   by the single read and single write port of the window memory.
// Reset: synchronous, active low. The window reads as zero at reset through a
//   fill count, so no clearing pass is needed and input is taken right away.
// Stall: when out_ready is low the output register holds, the copy run freezes
//   and in_ready drops until the pending word is taken.
module lzss_stream_decompressor_core #(
  parameter int BREAK_EVEN = lzss_pkg::BREAK_EVEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lzss_pkg::BYTE_W-1:0]  in_comp_byte,
  input  logic                         in_end_of_input,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lzss_pkg::BYTE_W-1:0]  out_plain_byte,
  output logic                         out_has_data,
  output logic                         out_run_last,
  output logic                         out_stream_done,
  output logic                         out_truncated,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lzss_pkg::LEN_W-1:0]   cfg_output_length
);

  lzss_pkg::cmd_t cmd;
  lzss_pkg::sts_t sts;

  // the length register takes a write in any cycle
  assign cfg_ready = 1'b1;

  // parse flags and sequence literals, tokens and copy runs
  lzss_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_comp_byte    (in_comp_byte),
    .in_end_of_input (in_end_of_input),
    .sts             (sts),
    .cmd             (cmd)
  );

  // hold the window, counters and the output register
  lzss_dpath #(
    .BREAK_EVEN (BREAK_EVEN)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_comp_byte      (in_comp_byte),
    .in_end_of_input   (in_end_of_input),
    .cfg_valid         (cfg_valid),
    .cfg_output_length (cfg_output_length),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_plain_byte    (out_plain_byte),
    .out_has_data      (out_has_data),
    .out_run_last      (out_run_last),
    .out_stream_done   (out_stream_done),
    .out_truncated     (out_truncated)
  );

endmodule
